FILE: design/tsb_pkg.sv
package tsb_pkg;

  localparam int MAX_SIZE_DEFAULT    = 256;
  localparam int WEIGHT_BITS_DEFAULT = 8;

  localparam int FRAC_BITS = 16;
  localparam logic [FRAC_BITS-1:0] FRAC_MAX = 16'hFFFF;
  localparam int HALF_TEXEL = 32768;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int SIZE_REG_W = 9;

  typedef enum logic [2:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_WRAP_U       = 3'd2,
    REG_WRAP_V       = 3'd3,
    REG_FILTER_MODE  = 3'd4
  } reg_index_t;

  localparam logic ACT_WRITE     = 1'b0;
  localparam logic ACT_SAMPLE    = 1'b1;
  localparam logic WRAP_CLAMP    = 1'b0;
  localparam logic WRAP_REPEAT   = 1'b1;
  localparam logic FILT_NEAREST  = 1'b0;
  localparam logic FILT_BILINEAR = 1'b1;

  typedef struct packed {
    logic en;
    logic we;
  } mem_ctl_t;

endpackage

FILE: design/tsb_if.sv
interface tsb_sample_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [7:0]  texel_x;
  logic [7:0]  texel_y;
  logic [31:0] texel_value;
  logic signed [23:0] coord_u;
  logic signed [23:0] coord_v;

  modport source (output valid, action, texel_x, texel_y, texel_value, coord_u, coord_v,
                  input ready);
  modport sink (input valid, action, texel_x, texel_y, texel_value, coord_u, coord_v,
                output ready);
endinterface

interface tsb_color_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;

  modport source (output valid, red, green, blue, alpha, input ready);
  modport sink (input valid, red, green, blue, alpha, output ready);
endinterface

FILE: design/tsb_texel_ram.sv
module tsb_texel_ram #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic              clk,
  input  tsb_pkg::mem_ctl_t ctl,
  input  logic [AW-1:0]     addr,
  input  logic [31:0]       wdata,
  output logic [31:0]       rdata
);
  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      if (ctl.we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end
endmodule

FILE: design/texture_sampler_bilinear.sv
// Channel   Direction  Contents
// sample    in         write texel or sample coordinates (valid/ready)
// color     out        filtered RGBA8 color, one per sample (valid/ready)
// apb       in/out     configuration registers, always ready
//
// A bilinear sample makes four reads on the single texel memory port, a nearest sample
// one, and a texel write one access; the port is the limit on rate.
// Reset clears the pipeline and restores register defaults; texel contents stay undefined.
// A stalled result holds only the last memory read of the next sample; earlier work goes on.
module texture_sampler_bilinear #(
  parameter int MAX_SIZE    = tsb_pkg::MAX_SIZE_DEFAULT,
  parameter int WEIGHT_BITS = tsb_pkg::WEIGHT_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  tsb_sample_if.sink                    sample,
  tsb_color_if.source                   color,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tsb_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [tsb_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [tsb_pkg::CFG_DATA_W-1:0] prdata,
  output logic                          pready
);
  import tsb_pkg::*;

  localparam int IW    = $clog2(MAX_SIZE);
  localparam int SW    = $clog2(MAX_SIZE + 1);
  localparam int PW    = FRAC_BITS + SW;
  localparam int DEPTH = MAX_SIZE * MAX_SIZE;
  localparam int AW    = $clog2(DEPTH);
  localparam int WB    = WEIGHT_BITS;
  localparam int KW    = 2 * WB + 1;
  localparam int ACW   = 2 * WB + 8;
  localparam logic [ACW-1:0] ROUND = ACW'(1) << (2 * WB - 1);
  localparam logic [WB:0] SCALE = (WB + 1)'(1) << WB;

  logic [SIZE_REG_W-1:0] image_width, image_height;
  logic wrap_u, wrap_v, filter_mode;

  logic cfg_write;
  reg_index_t cfg_index;
  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_index = reg_index_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= SIZE_REG_W'(1);
      image_height <= SIZE_REG_W'(1);
      wrap_u       <= WRAP_REPEAT;
      wrap_v       <= WRAP_REPEAT;
      filter_mode  <= FILT_NEAREST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= pwdata[SIZE_REG_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[SIZE_REG_W-1:0];
        REG_WRAP_U:       wrap_u       <= pwdata[0];
        REG_WRAP_V:       wrap_v       <= pwdata[0];
        REG_FILTER_MODE:  filter_mode  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_index)
      REG_IMAGE_WIDTH:  prdata = CFG_DATA_W'(image_width);
      REG_IMAGE_HEIGHT: prdata = CFG_DATA_W'(image_height);
      REG_WRAP_U:       prdata = CFG_DATA_W'(wrap_u);
      REG_WRAP_V:       prdata = CFG_DATA_W'(wrap_v);
      REG_FILTER_MODE:  prdata = CFG_DATA_W'(filter_mode);
      default:          prdata = '0;
    endcase
  end

  logic [SW-1:0] w_eff, h_eff;
  always_comb begin
    if (image_width == '0) w_eff = SW'(1);
    else if (32'(image_width) > MAX_SIZE) w_eff = SW'(MAX_SIZE);
    else w_eff = SW'(image_width);
    if (image_height == '0) h_eff = SW'(1);
    else if (32'(image_height) > MAX_SIZE) h_eff = SW'(MAX_SIZE);
    else h_eff = SW'(image_height);
  end

  logic bil;
  assign bil = (filter_mode == FILT_BILINEAR);

  // Pipeline handshake.
  logic st1_valid, st2_valid, sq_valid;
  logic sq_take, st2_adv, st2_take, st1_adv, in_take, sq_done, can_last, sq_last;
  logic out_valid;
  logic rd_valid, rd_first, rd_last;
  logic sq_action, sq_bil;
  logic [1:0] sq_cnt;

  assign sq_last  = sq_bil ? (sq_cnt == 2'd3) : 1'b1;
  assign can_last = !(rd_valid && rd_last) && (!out_valid || color.ready);
  assign sq_done  = sq_valid && ((sq_action == ACT_WRITE) || (sq_last && can_last));
  assign sq_take  = !sq_valid || sq_done;
  assign st2_adv  = st2_valid && sq_take;
  assign st2_take = !st2_valid || st2_adv;
  assign st1_adv  = st1_valid && st2_take;
  assign in_take  = !st1_valid || st1_adv;
  assign sample.ready = in_take;

  // Stage 1: wrap to a fraction, capture write fields.
  function automatic logic [FRAC_BITS-1:0] wrap_frac(input logic signed [23:0] c,
                                                     input logic repeat_mode);
    logic [FRAC_BITS-1:0] f;
    if (repeat_mode == WRAP_REPEAT) f = c[FRAC_BITS-1:0];
    else if (c < 0) f = '0;
    else if (c > $signed(24'(FRAC_MAX))) f = FRAC_MAX;
    else f = c[FRAC_BITS-1:0];
    return f;
  endfunction

  logic st1_action, st1_wok;
  logic [IW-1:0] st1_wx, st1_wy;
  logic [31:0] st1_val;
  logic [FRAC_BITS-1:0] st1_fu, st1_fv;

  always_ff @(posedge clk) begin
    if (rst) begin
      st1_valid <= 1'b0;
    end else if (in_take) begin
      st1_valid <= sample.valid;
    end
    if (in_take) begin
      st1_action <= sample.action;
      st1_wok    <= (32'(sample.texel_x) < MAX_SIZE) && (32'(sample.texel_y) < MAX_SIZE);
      st1_wx     <= IW'(sample.texel_x);
      st1_wy     <= IW'(sample.texel_y);
      st1_val    <= sample.texel_value;
      st1_fu     <= wrap_frac(sample.coord_u, wrap_u);
      st1_fv     <= wrap_frac(sample.coord_v, wrap_v);
    end
  end

  // Stage 2: scale by the image size.
  logic st2_action, st2_wok;
  logic [IW-1:0] st2_wx, st2_wy;
  logic [31:0] st2_val;
  logic [SW-1:0] st2_hx, st2_hy;
  logic [WB-1:0] st2_wu, st2_wv;
  logic [PW-1:0] sx, sy;

  assign sx = PW'(st1_fu) * PW'(w_eff) + (bil ? PW'(HALF_TEXEL) : PW'(0));
  assign sy = PW'(st1_fv) * PW'(h_eff) + (bil ? PW'(HALF_TEXEL) : PW'(0));

  always_ff @(posedge clk) begin
    if (rst) begin
      st2_valid <= 1'b0;
    end else if (st2_take) begin
      st2_valid <= st1_valid;
    end
    if (st2_take) begin
      st2_action <= st1_action;
      st2_wok    <= st1_wok;
      st2_wx     <= st1_wx;
      st2_wy     <= st1_wy;
      st2_val    <= st1_val;
      st2_hx     <= sx[PW-1:FRAC_BITS];
      st2_hy     <= sy[PW-1:FRAC_BITS];
      st2_wu     <= bil ? sx[FRAC_BITS-1 -: WB] : '0;
      st2_wv     <= bil ? sy[FRAC_BITS-1 -: WB] : '0;
    end
  end

  // Stage 3: neighbor indexes and weights, then the memory sequencer.
  function automatic logic [IW-1:0] idx_lo(input logic [SW-1:0] hi, input logic [SW-1:0] n,
                                           input logic rep, input logic bl);
    logic [IW-1:0] r;
    if (!bl) r = IW'(hi);
    else if (hi == '0) r = (rep == WRAP_REPEAT) ? IW'(n - SW'(1)) : '0;
    else r = IW'(hi - SW'(1));
    return r;
  endfunction

  function automatic logic [IW-1:0] idx_hi(input logic [SW-1:0] hi, input logic [SW-1:0] n,
                                           input logic rep);
    logic [IW-1:0] r;
    if (hi == n) r = (rep == WRAP_REPEAT) ? '0 : IW'(n - SW'(1));
    else r = IW'(hi);
    return r;
  endfunction

  logic sq_wok;
  logic [31:0] sq_val;
  logic [IW-1:0] sq_xa, sq_xb, sq_ya, sq_yb;
  logic [KW-1:0] sq_k [4];
  logic [WB:0] iu, iv;

  assign iu = SCALE - (WB + 1)'(st2_wu);
  assign iv = SCALE - (WB + 1)'(st2_wv);

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid <= 1'b0;
      sq_cnt   <= 2'd0;
    end else if (sq_take) begin
      sq_valid <= st2_valid;
      sq_cnt   <= 2'd0;
    end else if (sq_action == ACT_SAMPLE && !sq_last) begin
      sq_cnt <= sq_cnt + 2'd1;
    end
    if (sq_take) begin
      sq_action <= st2_action;
      sq_bil    <= bil;
      sq_wok    <= st2_wok;
      sq_val    <= st2_val;
      if (st2_action == ACT_WRITE) begin
        sq_xa <= st2_wx;
        sq_ya <= st2_wy;
      end else begin
        sq_xa <= idx_lo(st2_hx, w_eff, wrap_u, bil);
        sq_ya <= idx_lo(st2_hy, h_eff, wrap_v, bil);
      end
      sq_xb   <= idx_hi(st2_hx, w_eff, wrap_u);
      sq_yb   <= idx_hi(st2_hy, h_eff, wrap_v);
      sq_k[0] <= KW'(iu) * KW'(iv);
      sq_k[1] <= KW'(st2_wu) * KW'(iv);
      sq_k[2] <= KW'(iu) * KW'(st2_wv);
      sq_k[3] <= KW'(st2_wu) * KW'(st2_wv);
    end
  end

  mem_ctl_t mem_ctl;
  logic [IW-1:0] mx, my;
  logic [AW-1:0] mem_addr;
  logic [31:0] mem_rdata;

  assign mx = sq_cnt[0] ? sq_xb : sq_xa;
  assign my = sq_cnt[1] ? sq_yb : sq_ya;
  assign mem_addr = AW'(my) * AW'(MAX_SIZE) + AW'(mx);
  assign mem_ctl.we = (sq_action == ACT_WRITE);
  assign mem_ctl.en = sq_valid && ((sq_action == ACT_WRITE) ? sq_wok : (!sq_last || can_last));

  tsb_texel_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk  (clk),
    .ctl  (mem_ctl),
    .addr (mem_addr),
    .wdata(sq_val),
    .rdata(mem_rdata)
  );

  logic [KW-1:0] rd_k;
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= mem_ctl.en && !mem_ctl.we;
    end
    rd_first <= (sq_cnt == 2'd0);
    rd_last  <= sq_last;
    rd_k     <= sq_k[sq_cnt];
  end

  // Weighted accumulation of the fetched texels.
  logic [ACW-1:0] acc [4];
  logic [ACW-1:0] acc_next [4];
  always_comb begin
    for (int ch = 0; ch < 4; ch++) begin
      acc_next[ch] = (rd_first ? ROUND : acc[ch])
                   + ACW'(rd_k) * ACW'(mem_rdata[8*ch +: 8]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rd_valid && rd_last) begin
      out_valid <= 1'b1;
    end else if (color.ready) begin
      out_valid <= 1'b0;
    end
    if (rd_valid) begin
      for (int ch = 0; ch < 4; ch++) acc[ch] <= acc_next[ch];
    end
    if (rd_valid && rd_last) begin
      color.red   <= acc_next[0][2*WB +: 8];
      color.green <= acc_next[1][2*WB +: 8];
      color.blue  <= acc_next[2][2*WB +: 8];
      color.alpha <= acc_next[3][2*WB +: 8];
    end
  end

  assign color.valid = out_valid;

  a_last_fills_out: assert property (@(posedge clk) disable iff (rst)
    rd_valid && rd_last |=> out_valid)
    else $error("last texel read did not produce a result");

  a_last_needs_room: assert property (@(posedge clk) disable iff (rst)
    mem_ctl.en && !mem_ctl.we && sq_last |-> !out_valid || color.ready)
    else $error("final read issued while the result register stays full");

  a_nearest_one_read: assert property (@(posedge clk) disable iff (rst)
    sq_valid && !sq_bil |-> sq_cnt == 2'd0)
    else $error("nearest sample advanced past its single read");

  a_neighbor_reads_bilinear: assert property (@(posedge clk) disable iff (rst)
    mem_ctl.en && !mem_ctl.we && sq_cnt != 2'd0 |-> sq_bil)
    else $error("neighbor texel read issued for a sample that is not bilinear");
endmodule
